// ===== hw/rtl/space_layer_hold_shift_remapper_assert.svh =====
// assertion macros used by the remapper back part
// depends on clk_i and rst_ni in the including module
`ifndef SPACE_LAYER_HOLD_SHIFT_REMAPPER_ASSERT_SVH
`define SPACE_LAYER_HOLD_SHIFT_REMAPPER_ASSERT_SVH

// same-cycle implication
`define SLHSR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLHSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/slhsr_pkg.sv =====
// types, constants and codes of the layer/hold-shift remapper
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package slhsr_pkg;

  // map depth default
  localparam int unsigned MapDepth = 64;

  // command queue between front and back, power of two
  localparam int unsigned QueueDepth = 2;

  // event codes
  localparam logic [15:0] EvtKey   = 16'd1;
  localparam logic [15:0] EvtMisc  = 16'd4;
  localparam logic [15:0] MiscScan = 16'd4;

  // configuration register indexes
  localparam logic [1:0] RegHoldMs    = 2'd0;
  localparam logic [1:0] RegTableSize = 2'd1;
  localparam logic [1:0] RegShiftCode = 2'd2;
  localparam logic [1:0] RegLayerCode = 2'd3;

  // configuration reset values
  localparam logic [15:0] HoldMsRst    = 16'd200;
  localparam logic [6:0]  TableSizeRst = 7'd0;
  localparam logic [15:0] ShiftCodeRst = 16'd42;
  localparam logic [15:0] LayerCodeRst = 16'd57;

  // hold time arithmetic: ms per second, usec to ms by reciprocal
  localparam int unsigned MsPerSec = 1000;
  localparam logic [20:0] DivK     = 21'd1073742;  // ceil(2^30 / 1000)
  localparam int unsigned DivShift = 30;
  localparam int unsigned UqW      = 11;

  typedef struct packed {
    logic [15:0] hold_ms;
    logic [6:0]  table_size;
    logic [15:0] shift_code;
    logic [15:0] layer_code;
  } cfg_t;

  typedef struct packed {
    logic               mode;
    logic [15:0]        ev_type;
    logic [15:0]        ev_code;
    logic signed [31:0] ev_value;
    logic [31:0]        time_sec;
    logic [19:0]        time_usec;
    logic [5:0]         entry_index;
    logic [15:0]        entry_alt_key;
    logic               entry_has_alt;
    logic               entry_alt_capital;
    logic               entry_alt_shift;
    logic               entry_capital;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        out_type;
    logic [15:0]        out_code;
    logic signed [31:0] out_value;
    logic [31:0]        out_sec;
    logic [19:0]        out_usec;
    logic               out_last;
  } out_item_t;

  // item class decided by the front
  typedef enum logic [1:0] {
    KindLoad  = 2'd0,
    KindPass  = 2'd1,
    KindLayer = 2'd2,
    KindKey   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e    kind;
    logic     val_down;
    logic     val_up;
    in_item_t item;
  } cmd_t;

  typedef struct packed {
    logic [15:0] base_key;
    logic [15:0] alt_key;
    logic        has_alt;
    logic        alt_capital;
    logic        alt_shift;
  } map_entry_t;

  typedef struct packed {
    logic [31:0] sec;
    logic [19:0] usec;
  } press_t;

endpackage

`default_nettype wire

// ===== hw/rtl/slhsr_if.sv =====
// valid/ready stream interfaces for input items and result items
// depends on slhsr_pkg
`timescale 1ns / 1ps
`default_nettype none

interface slhsr_in_if;
  logic                valid;
  logic                ready;
  slhsr_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface slhsr_out_if;
  logic                 valid;
  logic                 ready;
  slhsr_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/slhsr_front.sv =====
// front stage: takes input items, drops scan events, classifies the rest
// depends on slhsr_pkg and slhsr_if
`timescale 1ns / 1ps
`default_nettype none

module slhsr_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [15:0]       layer_code_i,
  slhsr_in_if.sink               in_i,
  output      logic              push_valid_o,
  input  wire logic              push_ready_i,
  output      slhsr_pkg::cmd_t   push_data_o
);
  import slhsr_pkg::*;

  logic vld_q, vld_d;
  cmd_t cmd_q, cmd_d;
  logic in_xfer;
  logic is_scan;

  assign in_i.ready = !vld_q || push_ready_i;
  assign in_xfer    = in_i.valid && in_i.ready;

  // classify the incoming item
  always_comb begin
    is_scan       = !in_i.data.mode && (in_i.data.ev_type == EvtMisc) &&
                    (in_i.data.ev_code == MiscScan);
    cmd_d.item     = in_i.data;
    cmd_d.val_down = (in_i.data.ev_value == 32'sd1);
    cmd_d.val_up   = (in_i.data.ev_value == 32'sd0);
    priority if (in_i.data.mode) begin
      cmd_d.kind = KindLoad;
    end else if (in_i.data.ev_type != EvtKey) begin
      cmd_d.kind = KindPass;
    end else if (in_i.data.ev_code == layer_code_i) begin
      cmd_d.kind = KindLayer;
    end else begin
      cmd_d.kind = KindKey;
    end
  end

  // stage occupancy
  always_comb begin
    vld_d = vld_q;
    if (in_xfer) begin
      vld_d = !is_scan;
    end else if (push_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q <= cmd_d;
    end
  end

  assign push_valid_o = vld_q;
  assign push_data_o  = cmd_q;

endmodule

`default_nettype wire

// ===== hw/rtl/slhsr_queue.sv =====
// short command queue that decouples the front from the back
// depends on slhsr_pkg
`timescale 1ns / 1ps
`default_nettype none

module slhsr_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_valid_i,
  output      logic            push_ready_o,
  input  wire slhsr_pkg::cmd_t push_data_i,
  output      logic            pop_valid_o,
  input  wire logic            pop_ready_i,
  output      slhsr_pkg::cmd_t pop_data_o
);
  import slhsr_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            slot_q [QueueDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slot_q[rptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= wptr_q + PtrW'(1);
      end
      if (pop) begin
        rptr_q <= rptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/slhsr_back.sv =====
// back part: keymap search, press times, layer state and result sequencing
// depends on slhsr_pkg, slhsr_if and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "space_layer_hold_shift_remapper_assert.svh"

module slhsr_back #(
  parameter int unsigned MAP_DEPTH = slhsr_pkg::MapDepth
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire slhsr_pkg::cfg_t cfg_i,
  input  wire logic            q_valid_i,
  output      logic            q_ready_o,
  input  wire slhsr_pkg::cmd_t q_data_i,
  slhsr_out_if.source          out_o
);
  import slhsr_pkg::*;

  localparam int unsigned AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int unsigned CW = $clog2(MAP_DEPTH + 1);
  localparam int unsigned LW = (CW > 7) ? CW : 7;
  localparam int unsigned IW = (AW > 6) ? AW : 6;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_PRESS  = 5'b00100,
    S_CALC   = 5'b01000,
    S_EMIT   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // control registers
  logic [LW-1:0] ptr_q, ptr_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] pidx_q, pidx_d;
  logic          held_q, held_d;
  logic          consumed_q, consumed_d;
  logic          out_valid_q, out_valid_d;

  // payload registers
  cmd_t      cmd_q, cmd_d;
  logic      em_pass_q, em_pass_d;
  logic      em_shift_q, em_shift_d;
  logic [15:0] em_code_q, em_code_d;
  logic [1:0]  em_cnt_q, em_cnt_d;
  out_item_t out_q, out_d;

  // memories
  map_entry_t map_mem [MAP_DEPTH];
  map_entry_t map_rd_q;
  press_t     press_mem [MAP_DEPTH];
  press_t     press_rd_q;
  logic [MAP_DEPTH-1:0] press_vld_q;
  logic                 pvld_rd_q;

  logic          map_we, map_re, press_we, press_re;
  logic [AW-1:0] map_waddr;
  logic [IW-1:0] widx;
  logic          widx_ok;
  map_entry_t    map_wdata;
  logic [LW-1:0] lim;
  logic          q_pop, out_free, out_load, hit;

  // hold time datapath
  press_t              press_val;
  logic signed [32:0]  sdiff;
  logic signed [20:0]  udiff;
  logic [19:0]         umag;
  logic [40:0]         uprod;
  logic signed [43:0]  sdiff_ms_q, sdiff_ms_d;
  logic [UqW-1:0]      uq_q, uq_d;
  logic                uneg_q, uneg_d;
  logic signed [43:0]  uterm, dur;
  logic                long_hold, use_alt;
  logic [1:0]          pos;

  // search limit, capped at the map depth
  assign lim = (LW'(cfg_i.table_size) >= LW'(MAP_DEPTH)) ? LW'(MAP_DEPTH)
                                                          : LW'(cfg_i.table_size);

  // map write address and contents from a load command
  assign widx      = IW'(q_data_i.item.entry_index);
  assign map_waddr = widx[AW-1:0];
  assign widx_ok   = (32'(q_data_i.item.entry_index) < MAP_DEPTH);
  assign map_wdata = '{base_key:    q_data_i.item.ev_code,
                       alt_key:     q_data_i.item.entry_alt_key,
                       has_alt:     q_data_i.item.entry_has_alt,
                       alt_capital: q_data_i.item.entry_alt_capital,
                       alt_shift:   q_data_i.item.entry_alt_shift};

  assign hit       = pend_q && (map_rd_q.base_key == cmd_q.item.ev_code);
  assign out_free  = !out_valid_q || out_o.ready;
  assign q_ready_o = (state_q == S_IDLE);
  assign q_pop     = q_valid_i && q_ready_o;

  // first hold-time step: second difference times 1000, usec difference / 1000
  always_comb begin
    press_val  = pvld_rd_q ? press_rd_q : '0;
    sdiff      = $signed({1'b0, cmd_q.item.time_sec}) - $signed({1'b0, press_val.sec});
    udiff      = $signed({1'b0, cmd_q.item.time_usec}) - $signed({1'b0, press_val.usec});
    umag       = udiff[20] ? 20'(-udiff) : 20'(udiff);
    uprod      = 41'(umag) * 41'(DivK);
    sdiff_ms_d = 44'(sdiff) * $signed(44'(MsPerSec));
    uq_d       = uprod[DivShift +: UqW];
    uneg_d     = udiff[20];
  end

  // second step: sum, compare and key choice
  always_comb begin
    uterm     = uneg_q ? -$signed({33'b0, uq_q}) : $signed({33'b0, uq_q});
    dur       = sdiff_ms_q + uterm;
    long_hold = dur > $signed({28'b0, cfg_i.hold_ms});
    use_alt   = map_rd_q.has_alt && (map_rd_q.alt_key != 16'd0) && held_q;
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    pend_d     = 1'b0;
    pidx_d     = pidx_q;
    held_d     = held_q;
    consumed_d = consumed_q;
    cmd_d      = cmd_q;
    em_pass_d  = em_pass_q;
    em_shift_d = em_shift_q;
    em_code_d  = em_code_q;
    em_cnt_d   = em_cnt_q;
    map_we     = 1'b0;
    map_re     = 1'b0;
    press_we   = 1'b0;
    press_re   = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (q_pop) begin
          cmd_d = q_data_i;
          unique case (q_data_i.kind)
            KindLoad: begin
              map_we = widx_ok;
            end
            KindPass: begin
              em_pass_d = 1'b1;
              em_cnt_d  = 2'd0;
              state_d   = S_EMIT;
            end
            KindLayer: begin
              if (q_data_i.val_down) begin
                held_d     = 1'b1;
                consumed_d = 1'b0;
              end else if (q_data_i.val_up) begin
                held_d     = 1'b0;
                consumed_d = 1'b0;
                if (!consumed_q) begin
                  em_pass_d  = 1'b0;
                  em_shift_d = 1'b0;
                  em_code_d  = cfg_i.layer_code;
                  em_cnt_d   = 2'd0;
                  state_d    = S_EMIT;
                end
              end
            end
            KindKey: begin
              ptr_d   = '0;
              state_d = S_SEARCH;
            end
          endcase
        end
      end
      S_SEARCH: begin
        priority if (hit) begin
          consumed_d = 1'b1;
          if (cmd_q.val_down) begin
            press_we = 1'b1;
            state_d  = S_IDLE;
          end else if (cmd_q.val_up) begin
            press_re = 1'b1;
            state_d  = S_PRESS;
          end else begin
            state_d = S_IDLE;
          end
        end else if (ptr_q < lim) begin
          map_re = 1'b1;
          pend_d = 1'b1;
          pidx_d = ptr_q[AW-1:0];
          ptr_d  = ptr_q + LW'(1);
        end else begin
          em_pass_d = 1'b1;
          em_cnt_d  = 2'd0;
          state_d   = S_EMIT;
        end
      end
      S_PRESS: begin
        state_d = S_CALC;
      end
      S_CALC: begin
        em_pass_d  = 1'b0;
        em_cnt_d   = 2'd0;
        em_code_d  = use_alt ? map_rd_q.alt_key : map_rd_q.base_key;
        em_shift_d = use_alt ? ((map_rd_q.alt_capital && long_hold) || map_rd_q.alt_shift)
                             : long_hold;
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (out_d.out_last) begin
            state_d = S_IDLE;
          end else begin
            em_cnt_d = em_cnt_q + 2'd1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // result builder: optional shift down, key down, key up, optional shift up
  always_comb begin
    pos = em_shift_q ? em_cnt_q : em_cnt_q + 2'd1;
    out_d.out_type = EvtKey;
    out_d.out_last = em_shift_q ? (em_cnt_q == 2'd3) : (em_cnt_q == 2'd1);
    out_d.out_sec  = cmd_q.item.time_sec;
    out_d.out_usec = cmd_q.item.time_usec;
    unique case (pos)
      2'd0: begin
        out_d.out_code  = cfg_i.shift_code;
        out_d.out_value = 32'sd1;
        out_d.out_sec   = '0;
        out_d.out_usec  = '0;
      end
      2'd1: begin
        out_d.out_code  = em_code_q;
        out_d.out_value = 32'sd1;
      end
      2'd2: begin
        out_d.out_code  = em_code_q;
        out_d.out_value = 32'sd0;
      end
      2'd3: begin
        out_d.out_code  = cfg_i.shift_code;
        out_d.out_value = 32'sd0;
        out_d.out_sec   = '0;
        out_d.out_usec  = '0;
      end
    endcase
    // pass-through keeps the whole input event, whatever the tap flags hold
    if (em_pass_q) begin
      out_d.out_type  = cmd_q.item.ev_type;
      out_d.out_code  = cmd_q.item.ev_code;
      out_d.out_value = cmd_q.item.ev_value;
      out_d.out_sec   = cmd_q.item.time_sec;
      out_d.out_usec  = cmd_q.item.time_usec;
      out_d.out_last  = 1'b1;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      held_q      <= 1'b0;
      consumed_q  <= 1'b0;
      out_valid_q <= 1'b0;
      press_vld_q <= '0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      pend_q      <= pend_d;
      held_q      <= held_d;
      consumed_q  <= consumed_d;
      out_valid_q <= out_valid_d;
      if (press_we) begin
        press_vld_q[pidx_q] <= 1'b1;
      end
    end
  end

  // payload state
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    pidx_q     <= pidx_d;
    em_pass_q  <= em_pass_d;
    em_shift_q <= em_shift_d;
    em_code_q  <= em_code_d;
    em_cnt_q   <= em_cnt_d;
    if (out_load) begin
      out_q <= out_d;
    end
    if (state_q == S_PRESS) begin
      sdiff_ms_q <= sdiff_ms_d;
      uq_q       <= uq_d;
      uneg_q     <= uneg_d;
    end
  end

  // keymap memory
  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    if (map_re) begin
      map_rd_q <= map_mem[ptr_q[AW-1:0]];
    end
  end

  // press time memory, unwritten slots read as zero via valid bits
  always_ff @(posedge clk_i) begin
    if (press_we) begin
      press_mem[pidx_q] <= '{sec: cmd_q.item.time_sec, usec: cmd_q.item.time_usec};
    end
    if (press_re) begin
      press_rd_q <= press_mem[pidx_q];
      pvld_rd_q  <= press_vld_q[pidx_q];
    end
  end

  `SLHSR_ASSERT_NEXT(a_press_wr_ends, press_we, state_q == S_IDLE, "press write did not end item")
  `SLHSR_ASSERT_IMPL(a_ptr_in_lim, state_q == S_SEARCH, ptr_q <= lim, "search pointer past limit")
  `SLHSR_ASSERT_IMPL(a_tap_len, (state_q == S_EMIT) && !em_pass_q && !em_shift_q, em_cnt_q <= 2'd1, "plain tap longer than two results")
  `SLHSR_ASSERT_NEXT(a_last_idle, out_load && out_d.out_last, state_q == S_IDLE, "sequencer busy after last result")

endmodule

`default_nettype wire

// ===== hw/rtl/space_layer_hold_shift_remapper.sv =====
// top level of the layer-key and hold-for-shift keyboard event remapper
// depends on slhsr_pkg, slhsr_if, slhsr_front, slhsr_queue and slhsr_back
`timescale 1ns / 1ps
`default_nettype none

// Filters keyboard events: scan events vanish, non-key events and unmapped
// keys pass through, the layer key becomes a tap on release unless a mapped
// key was used while it was down, and a mapped key is sent on release as a
// down/up pair of its base or alternate key, wrapped in shift events when held
// longer than hold_ms (an alternate key: when alt_shift is set, or alt_capital
// is set and it was held that long). Map entries are loaded as items with mode
// set. The front registers and classifies one item per cycle, while the queue
// has room, into a two-entry command queue; the back works on one command at a
// time. A key event adds a keymap search at one memory read a cycle over the
// first L = min(table_size, MAP_DEPTH) slots, up to the first match. A mapped
// release then reads its press time, works out the hold time and the key
// choice, and sends its 2 or 4 results as the output takes them. No clearing
// pass is needed after reset. Configuration is to be written by the user only
// while idle; the block itself does not enforce this.
module space_layer_hold_shift_remapper #(
  parameter int unsigned MAP_DEPTH = slhsr_pkg::MapDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  slhsr_in_if.sink         in_i,
  slhsr_out_if.source      out_o
);
  import slhsr_pkg::*;

  cfg_t cfg_q;
  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_data, pop_data;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_ms    <= HoldMsRst;
      cfg_q.table_size <= TableSizeRst;
      cfg_q.shift_code <= ShiftCodeRst;
      cfg_q.layer_code <= LayerCodeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegHoldMs:    cfg_q.hold_ms    <= cfg_data_i;
        RegTableSize: cfg_q.table_size <= cfg_data_i[6:0];
        RegShiftCode: cfg_q.shift_code <= cfg_data_i;
        RegLayerCode: cfg_q.layer_code <= cfg_data_i;
      endcase
    end
  end

  // classify stage
  slhsr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .layer_code_i (cfg_q.layer_code),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // command queue
  slhsr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // execution part
  slhsr_back #(
    .MAP_DEPTH (MAP_DEPTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (pop_valid),
    .q_ready_o (pop_ready),
    .q_data_i  (pop_data),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire

// ===== tb/space_layer_hold_shift_remapper_tb.sv =====
// self-checking testbench of the layer-key and hold-for-shift event remapper
// depends on slhsr_pkg, slhsr_if and the space_layer_hold_shift_remapper rtl
`timescale 1ns / 1ps

module space_layer_hold_shift_remapper_tb;
  import slhsr_pkg::*;

  localparam int unsigned HalfPeriod    = 10;
  localparam int unsigned ResetCycles   = 9;
  localparam int unsigned DrainCycles   = 400;
  localparam int unsigned StallLimit    = 3000;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned MaxGap        = 5;

  localparam logic ModeEvent = 1'b0;
  localparam logic ModeLoad  = 1'b1;

  localparam logic signed [31:0] KeyUp     = 32'sd0;
  localparam logic signed [31:0] KeyDown   = 32'sd1;
  localparam logic signed [31:0] KeyRepeat = 32'sd2;

  // keymap and layer tracker that predicts the emitted events
  class remap_scoreboard;
    logic [15:0] hold_ms;
    logic [6:0]  table_size;
    logic [15:0] shift_code;
    logic [15:0] layer_code;
    logic [15:0] map_base      [MapDepth];
    logic [15:0] map_alt       [MapDepth];
    logic        map_has_alt   [MapDepth];
    logic        map_alt_cap   [MapDepth];
    logic        map_alt_shift [MapDepth];
    logic        map_cap       [MapDepth];
    logic [31:0] press_sec     [MapDepth];
    logic [19:0] press_usec    [MapDepth];
    logic        layer_held;
    logic        layer_consumed;
    out_item_t   pending_q [$];
    int          errors;
    int          inputs_seen;
    int          results_seen;
    int          shifted_taps;
    int          alt_taps;

    function new();
      hold_ms        = HoldMsRst;
      table_size     = TableSizeRst;
      shift_code     = ShiftCodeRst;
      layer_code     = LayerCodeRst;
      layer_held     = 1'b0;
      layer_consumed = 1'b0;
      errors         = 0;
      inputs_seen    = 0;
      results_seen   = 0;
      shifted_taps   = 0;
      alt_taps       = 0;
      for (int i = 0; i < MapDepth; i++) begin
        map_base[i]      = '0;
        map_alt[i]       = '0;
        map_has_alt[i]   = 1'b0;
        map_alt_cap[i]   = 1'b0;
        map_alt_shift[i] = 1'b0;
        map_cap[i]       = 1'b0;
        press_sec[i]     = '0;
        press_usec[i]    = '0;
      end
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] value);
      case (idx)
        RegHoldMs:    hold_ms    = value;
        RegTableSize: table_size = value[6:0];
        RegShiftCode: shift_code = value;
        RegLayerCode: layer_code = value;
        default: ;
      endcase
    endfunction

    function void push_result(logic [15:0] typ, logic [15:0] code, logic signed [31:0] value,
                              logic [31:0] sec, logic [19:0] usec, logic is_last);
      out_item_t r;
      r.out_type  = typ;
      r.out_code  = code;
      r.out_value = value;
      r.out_sec   = sec;
      r.out_usec  = usec;
      r.out_last  = is_last;
      pending_q.push_back(r);
    endfunction

    // down/up pair, optionally wrapped in shift down/up with zero timestamps
    function void push_tap(logic [15:0] code, logic shifted, logic [31:0] sec, logic [19:0] usec);
      if (shifted) push_result(EvtKey, shift_code, KeyDown, '0, '0, 1'b0);
      push_result(EvtKey, code, KeyDown, sec, usec, 1'b0);
      push_result(EvtKey, code, KeyUp, sec, usec, !shifted);
      if (shifted) begin
        push_result(EvtKey, shift_code, KeyUp, '0, '0, 1'b1);
        shifted_taps++;
      end
    endfunction

    // called for every accepted input transfer
    function void note_input(in_item_t it);
      int      lim;
      int      hit;
      longint  dur;
      logic    long_hold;
      logic    shifted;
      inputs_seen++;

      // keymap load
      if (it.mode == ModeLoad) begin
        map_base[it.entry_index]      = it.ev_code;
        map_alt[it.entry_index]       = it.entry_alt_key;
        map_has_alt[it.entry_index]   = it.entry_has_alt;
        map_alt_cap[it.entry_index]   = it.entry_alt_capital;
        map_alt_shift[it.entry_index] = it.entry_alt_shift;
        map_cap[it.entry_index]       = it.entry_capital;
        return;
      end

      // scan events vanish, other non-key events pass
      if (it.ev_type == EvtMisc && it.ev_code == MiscScan) return;
      if (it.ev_type != EvtKey) begin
        push_result(it.ev_type, it.ev_code, it.ev_value, it.time_sec, it.time_usec, 1'b1);
        return;
      end

      // layer key: tap on release unless consumed
      if (it.ev_code == layer_code) begin
        if (it.ev_value == KeyDown) begin
          layer_held     = 1'b1;
          layer_consumed = 1'b0;
        end else if (it.ev_value == KeyUp) begin
          layer_held = 1'b0;
          if (!layer_consumed) push_tap(layer_code, 1'b0, it.time_sec, it.time_usec);
          layer_consumed = 1'b0;
        end
        return;
      end

      // first matching slot in table order
      lim = (table_size < MapDepth) ? int'(table_size) : MapDepth;
      hit = -1;
      for (int i = 0; i < lim; i++) begin
        if (hit < 0 && map_base[i] == it.ev_code) hit = i;
      end
      if (hit < 0) begin
        push_result(it.ev_type, it.ev_code, it.ev_value, it.time_sec, it.time_usec, 1'b1);
        return;
      end

      layer_consumed = 1'b1;
      if (it.ev_value == KeyDown) begin
        press_sec[hit]  = it.time_sec;
        press_usec[hit] = it.time_usec;
        return;
      end
      if (it.ev_value != KeyUp) return;

      // hold time in ms, signed with truncating division
      dur = ($signed({32'd0, it.time_sec}) - $signed({32'd0, press_sec[hit]})) * 1000 +
            ($signed({44'd0, it.time_usec}) - $signed({44'd0, press_usec[hit]})) / 1000;
      long_hold = dur > $signed({48'd0, hold_ms});
      if (map_has_alt[hit] && map_alt[hit] != 16'd0 && layer_held) begin
        shifted = (map_alt_cap[hit] && long_hold) || map_alt_shift[hit];
        alt_taps++;
        push_tap(map_alt[hit], shifted, it.time_sec, it.time_usec);
      end else begin
        push_tap(map_base[hit], long_hold, it.time_sec, it.time_usec);
      end
    endfunction

    task report(string what);
      errors++;
      $display("%0t: mismatch: %s", $time, what);
    endtask

    // called for every accepted result transfer
    task check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result type %h code %h value %0d",
                         got.out_type, got.out_code, got.out_value));
        return;
      end
      want = pending_q.pop_front();
      if (got.out_type !== want.out_type)
        report($sformatf("out_type got %h want %h", got.out_type, want.out_type));
      if (got.out_code !== want.out_code)
        report($sformatf("out_code got %h want %h", got.out_code, want.out_code));
      if (got.out_value !== want.out_value)
        report($sformatf("out_value got %0d want %0d (code %h)",
                         got.out_value, want.out_value, want.out_code));
      if (got.out_sec !== want.out_sec)
        report($sformatf("out_sec got %h want %h (code %h)",
                         got.out_sec, want.out_sec, want.out_code));
      if (got.out_usec !== want.out_usec)
        report($sformatf("out_usec got %h want %h (code %h)",
                         got.out_usec, want.out_usec, want.out_code));
      if (got.out_last !== want.out_last)
        report($sformatf("out_last got %b want %b (code %h)",
                         got.out_last, want.out_last, want.out_code));
    endtask
  endclass

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  slhsr_in_if  in_if ();
  slhsr_out_if out_if ();

  space_layer_hold_shift_remapper dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  remap_scoreboard sb;
  bit              no_idle      = 1'b0;
  bit              holdoff_req  = 1'b0;
  int unsigned     items_sent   = 0;
  int unsigned     stall_cycles = 0;
  longint          now_us       = 0;

  // clock
  always #(HalfPeriod) clk_i = ~clk_i;

  // transfer monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) sb.note_input(in_if.data);
      if (out_if.valid && out_if.ready) sb.check_result(out_if.data);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 StallLimit, sb.pending_q.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // result receiver with random stalls and one long hold-off
  initial begin
    int unsigned stall;
    out_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        stall = HoldOffCycles;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, MaxGap);
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  // random item with a legal timestamp
  function automatic in_item_t noise_item();
    logic [159:0] r;
    in_item_t     it;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom};
    it = r[$bits(in_item_t)-1:0];
    it.mode      = ModeEvent;
    it.time_usec = 20'($urandom_range(0, 999999));
    return it;
  endfunction

  // key event stamped with the running clock
  function automatic in_item_t key_item(logic [15:0] code, logic signed [31:0] value);
    in_item_t it;
    it = noise_item();
    it.ev_type   = EvtKey;
    it.ev_code   = code;
    it.ev_value  = value;
    it.time_sec  = 32'(now_us / 1000000);
    it.time_usec = 20'(now_us % 1000000);
    return it;
  endfunction

  // base key of a slot inside the searched part of the table
  function automatic logic [15:0] pick_mapped();
    int lim;
    lim = (sb.table_size < MapDepth) ? int'(sb.table_size) : MapDepth;
    if (lim == 0) return 16'($urandom);
    return sb.map_base[$urandom_range(0, lim - 1)];
  endfunction

  // hold time clustered around the long-hold threshold
  function automatic int unsigned rand_hold_ms();
    int unsigned h;
    int unsigned ms;
    h = 32'(sb.hold_ms);
    case ($urandom_range(0, 4))
      0:       ms = h;
      1:       ms = h + 1;
      2:       ms = (h > 0) ? h - 1 : 0;
      3:       ms = $urandom_range(0, 2 * h + 20);
      default: ms = $urandom_range(0, 50);
    endcase
    return ms;
  endfunction

  // one input transfer after a random gap
  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
  endtask

  // wait until every expected result is in and the block has gone quiet
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // write all four registers on back-to-back cycles, block idle
  task automatic apply_settings(logic [15:0] hold, logic [6:0] tsize, logic [15:0] shift,
                                logic [15:0] layer);
    logic [1:0]  regs [4];
    logic [15:0] vals [4];
    regs = '{RegHoldMs, RegTableSize, RegShiftCode, RegLayerCode};
    vals = '{hold, {9'd0, tsize}, shift, layer};
    for (int r = 0; r < 4; r++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= regs[r];
      cfg_data_i <= vals[r];
      @(posedge clk_i);
      sb.set_reg(regs[r], vals[r]);
    end
    cfg_we_i <= 1'b0;
    now_us = longint'($urandom) * 1000000 + $urandom_range(0, 999999);
    if (now_us > 64'd4290000000000000) now_us = now_us - 64'd10000000000000;
  endtask

  // press, optional repeat, release after ms milliseconds
  task automatic press_release(logic [15:0] code, int unsigned ms, bit with_repeat);
    send_item(key_item(code, KeyDown));
    if (with_repeat) send_item(key_item(code, KeyRepeat));
    now_us += longint'(ms) * 1000 + (($urandom_range(0, 1) == 1) ? $urandom_range(0, 999) : 0);
    send_item(key_item(code, KeyUp));
  endtask

  // mostly well-formed typing with layer chords, plus noise and broken sequences
  task automatic run_phase(int unsigned count);
    int unsigned       stop_at;
    int unsigned       pick;
    logic [15:0]       code;
    logic signed [31:0] value;
    longint            t0;
    bit                early;
    in_item_t          it;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      now_us += longint'($urandom_range(0, 3000)) * 1000;
      if (pick < 40) begin
        press_release(pick_mapped(), rand_hold_ms(), $urandom_range(0, 3) == 0);
      end else if (pick < 58) begin
        // layer chord, sometimes with a key pressed before the layer key
        code  = pick_mapped();
        early = $urandom_range(0, 3) == 0;
        if (early) send_item(key_item(code, KeyDown));
        send_item(key_item(sb.layer_code, KeyDown));
        repeat ($urandom_range(0, 3)) begin
          if ($urandom_range(0, 3) == 0) begin
            send_item(key_item(16'($urandom), KeyDown));
          end else begin
            press_release(pick_mapped(), rand_hold_ms(), 1'b0);
          end
        end
        if (early) begin
          now_us += longint'(rand_hold_ms()) * 1000;
          send_item(key_item(code, KeyUp));
        end
        now_us += longint'($urandom_range(0, 500)) * 1000;
        send_item(key_item(sb.layer_code, KeyUp));
      end else if (pick < 68) begin
        // key that is most likely not in the table
        value = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 2) : $urandom;
        send_item(key_item(16'($urandom), value));
      end else if (pick < 76) begin
        // non-key traffic and scan events
        it = noise_item();
        if ($urandom_range(0, 1) == 1) begin
          it.ev_type = EvtMisc;
          it.ev_code = MiscScan;
        end
        send_item(it);
      end else if (pick < 84) begin
        // reload a slot
        it = noise_item();
        it.mode        = ModeLoad;
        it.entry_index = 6'($urandom_range(0, MapDepth - 1));
        if ($urandom_range(0, 1) == 1) it.ev_code = 16'h1000 + 16'($urandom_range(0, 63));
        send_item(it);
      end else begin
        // broken sequences
        case ($urandom_range(0, 4))
          0: send_item(key_item(pick_mapped(), $urandom));
          1: send_item(key_item(sb.layer_code,
                                ($urandom_range(0, 1) == 1) ? KeyRepeat : $urandom));
          2: send_item(key_item(pick_mapped(), KeyUp));
          3: begin
            // release stamped before its press
            t0 = now_us;
            code = pick_mapped();
            now_us += longint'($urandom_range(1, 20000)) * 1000;
            send_item(key_item(code, KeyDown));
            now_us = t0;
            send_item(key_item(code, KeyUp));
            now_us += 64'd25000000;
          end
          default: begin
            it = noise_item();
            it.ev_type  = EvtKey;
            it.ev_code  = pick_mapped();
            it.ev_value = ($urandom_range(0, 1) == 1) ? KeyDown : KeyUp;
            send_item(it);
          end
        endcase
      end
    end
  endtask

  // stimulus
  initial begin
    in_item_t it;
    longint   t0;
    sb = new();
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= RegHoldMs;
    cfg_data_i  <= '0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pass-through at the field extremes, scan event, empty table
    it = noise_item();
    it.ev_type = 16'h0000; it.ev_code = 16'h0000; it.ev_value = 32'sh8000_0000;
    it.time_sec = 32'h0000_0000; it.time_usec = 20'd0;
    send_item(it);
    it = noise_item();
    it.ev_type = 16'hFFFF; it.ev_code = 16'hFFFF; it.ev_value = 32'sh7FFF_FFFF;
    it.time_sec = 32'hFFFF_FFFF; it.time_usec = 20'd999999;
    send_item(it);
    it = noise_item();
    it.ev_type = EvtMisc; it.ev_code = MiscScan;
    send_item(it);
    it = noise_item();
    it.ev_type = EvtMisc; it.ev_code = MiscScan + 16'd1;
    send_item(it);
    now_us = 64'd1000000000;
    send_item(key_item(16'h1005, KeyDown));

    // lone layer tap, with a repeat in between
    send_item(key_item(LayerCodeRst, KeyDown));
    send_item(key_item(LayerCodeRst, KeyRepeat));
    now_us += 64'd50000;
    send_item(key_item(LayerCodeRst, KeyUp));

    // fill every slot; a few slots carry the flag combinations under test
    for (int s = 0; s < MapDepth; s++) begin
      it = noise_item();
      it.mode          = ModeLoad;
      it.entry_index   = s[5:0];
      it.ev_code       = 16'h1000 + s[15:0];
      it.entry_alt_key = (s % 4 == 0) ? 16'h0000 : 16'h2000 + s[15:0];
      case (s)
        0:  it.ev_code = 16'h0000;
        1:  {it.entry_has_alt, it.entry_alt_capital, it.entry_alt_shift} = 3'b101;
        2:  {it.entry_has_alt, it.entry_alt_capital, it.entry_alt_shift} = 3'b110;
        3:  it.entry_has_alt = 1'b0;
        4:  it.entry_has_alt = 1'b1;
        10: it.ev_code = 16'h1005;
        62: it.entry_alt_key = 16'hFFFF;
        63: it.ev_code = 16'hFFFF;
        default: ;
      endcase
      send_item(it);
    end
    drain();
    apply_settings(HoldMsRst, 7'd64, ShiftCodeRst, LayerCodeRst);

    // base key taps: short, long with repeat in the deepest slot, duplicate key
    press_release(16'h0000, 1, 1'b0);
    press_release(16'hFFFF, 250, 1'b1);
    press_release(16'h1005, 5, 1'b0);

    // alternate keys under the layer key; the layer release then sends nothing
    send_item(key_item(LayerCodeRst, KeyDown));
    press_release(16'h1001, 5, 1'b0);
    press_release(16'h1002, 300, 1'b0);
    press_release(16'h1003, 5, 1'b0);
    press_release(16'h1004, 300, 1'b0);
    send_item(key_item(LayerCodeRst, KeyUp));

    // release stamped before its press, and an odd key value
    t0 = now_us;
    now_us += 64'd10000000;
    send_item(key_item(16'h1007, KeyDown));
    now_us = t0;
    send_item(key_item(16'h1007, KeyUp));
    send_item(key_item(16'h1008, -32'sd1));
    drain();

    // default-like settings with a long receiver hold-off and a mid-phase pause
    apply_settings(HoldMsRst, 7'd64, ShiftCodeRst, LayerCodeRst);
    run_phase(30);
    holdoff_req = 1'b1;
    run_phase(35);
    drain();
    run_phase(30);
    drain();

    // zero hold time, table size past the depth, all-ones codes, no idling at first
    apply_settings(16'd0, 7'd127, 16'hFFFF, 16'hFFFF);
    no_idle = 1'b1;
    run_phase(50);
    no_idle = 1'b0;
    run_phase(45);
    drain();

    // longest hold time, partial table, zero codes
    apply_settings(16'hFFFF, 7'd17, 16'h0000, 16'h0000);
    run_phase(90);
    drain();

    // random settings
    apply_settings(16'($urandom_range(1, 2000)), 7'($urandom_range(1, 64)),
                   16'($urandom), 16'($urandom));
    run_phase(90);
    drain();

    $display("covered %0d input transfers and %0d results over six register settings",
             sb.inputs_seen, sb.results_seen);
    $display("%0d shifted taps, %0d alternate-key taps, %0d mismatches",
             sb.shifted_taps, sb.alt_taps, sb.errors);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
